/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks that disappear in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define XCFU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define XCFU_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define XCFU_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define XCFU_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/xcfu_pkg.sv */
// ---------------------------------------------------------------------------
// xcfu_pkg
// Types and constants shared by the frame unpacker modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package xcfu_pkg;

   localparam int unsigned STORE_DEPTH = 29;

   localparam logic [7:0] HEADER_BYTE = 8'h16;
   localparam logic [7:0] LENGTH_BYTE = 8'd32;
   localparam logic [4:0] POS_HEADER  = 5'd0;
   localparam logic [4:0] POS_LENGTH  = 5'd1;
   localparam logic [4:0] POS_CHECK   = 5'd31;
   localparam logic [3:0] IDX_STATUS  = 4'd0;
   localparam logic [3:0] IDX_FIRST_WORD = 4'd1;
   localparam logic [3:0] IDX_LAST    = 4'd14;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_HEADER   = 2'd1;
   localparam logic [1:0] ERR_CHECKSUM = 2'd2;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [3:0]  field_index;
      logic [15:0] field_value;
      logic [1:0]  frame_error;
      logic        last_field;
   } rsp_type;

   // chain control: shift one place (fill or status), or two places (word)
   typedef struct packed {
      logic shift1;
      logic shift2;
   } chain_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

endpackage

/* rtl/xor_checked_frame_unpacker.sv */
// ---------------------------------------------------------------------------
// xor_checked_frame_unpacker
// 32-byte sensor frame parser with header, length and XOR checksum checks.
// ---------------------------------------------------------------------------
//
//   channel  dir  handshake              payload
//   req_     in   req_valid/req_ready    xcfu_pkg::req_type (rx_byte, frame_start)
//   rsp_     out  rsp_valid/rsp_ready    xcfu_pkg::rsp_type (index, value, error, last)
//
// One byte transfer per cycle while no drain runs and the output slot is free.
// A good frame end starts a drain of 14 words after the status result: one word
// per cycle, while the output slot is free, leaves the head of the 29-cell byte
// chain, no input taken meanwhile. Error results are a single result, no drain.
// Reset (synchronous) clears state, position, XOR, header flag, word index and
// output valid, not the byte chain. rsp_ready low simply holds the output slot.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xor_checked_frame_unpacker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  xcfu_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output xcfu_pkg::rsp_type rsp_data
);

   xcfu_pkg::state_type     state_ff, state_in;
   logic [4:0]              pos_ff, pos_in;
   logic [7:0]              xor_ff, xor_in;
   logic                    hg_ff, hg_in;
   logic [3:0]              idx_ff, idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   xcfu_pkg::rsp_type       rsp_ff, rsp_in;
   xcfu_pkg::chain_ctl_type ctl;

   logic       slot_free;
   logic       req_xfer;
   logic [4:0] pos_eff;
   logic [7:0] xor_eff;
   logic       hg_eff;
   logic [7:0] head0, head1;

   xcfu_byte_chain u_chain (
      .clock      (clock),
      .ctl        (ctl),
      .tail_byte  (req_data.rx_byte),
      .head_byte0 (head0),
      .head_byte1 (head1)
   );

   always_comb begin
      slot_free = !rsp_valid_ff || rsp_ready;
      req_ready = (state_ff == xcfu_pkg::ST_IDLE) && slot_free;
      req_xfer  = req_valid && req_ready;

      // start mark restarts the frame before the byte is taken
      pos_eff = req_data.frame_start ? xcfu_pkg::POS_HEADER : pos_ff;
      xor_eff = req_data.frame_start ? 8'h00 : xor_ff;
      hg_eff  = req_data.frame_start ? 1'b1 : hg_ff;

      state_in     = state_ff;
      pos_in       = pos_ff;
      xor_in       = xor_ff;
      hg_in        = hg_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      ctl          = '0;

      if (req_xfer) begin
         if (pos_eff != xcfu_pkg::POS_CHECK) begin
            if (pos_eff == xcfu_pkg::POS_HEADER) begin
               hg_in = (req_data.rx_byte == xcfu_pkg::HEADER_BYTE);
            end else if (pos_eff == xcfu_pkg::POS_LENGTH) begin
               hg_in = hg_eff && (req_data.rx_byte == xcfu_pkg::LENGTH_BYTE);
            end else begin
               ctl.shift1 = 1'b1;   // payload byte enters at the tail
            end
            xor_in = xor_eff ^ req_data.rx_byte;
            pos_in = pos_eff + 5'd1;
         end else begin
            // checksum byte: judge the frame, then restart
            pos_in       = xcfu_pkg::POS_HEADER;
            xor_in       = 8'h00;
            hg_in        = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_in.field_index = xcfu_pkg::IDX_STATUS;
            rsp_in.field_value = 16'h0000;
            rsp_in.last_field  = 1'b1;
            if (!hg_eff) begin
               rsp_in.frame_error = xcfu_pkg::ERR_HEADER;
            end else if (req_data.rx_byte != xor_eff) begin
               rsp_in.frame_error = xcfu_pkg::ERR_CHECKSUM;
            end else begin
               // status byte sits at the head; pop it
               rsp_in.frame_error = xcfu_pkg::ERR_NONE;
               rsp_in.field_value = {8'h00, head0};
               rsp_in.last_field  = 1'b0;
               ctl.shift1         = 1'b1;
               state_in           = xcfu_pkg::ST_DRAIN;
               idx_in             = xcfu_pkg::IDX_FIRST_WORD;
            end
         end
      end else if ((state_ff == xcfu_pkg::ST_DRAIN) && slot_free) begin
         // big-endian word from the two head cells
         rsp_valid_in       = 1'b1;
         rsp_in.field_index = idx_ff;
         rsp_in.field_value = {head0, head1};
         rsp_in.frame_error = xcfu_pkg::ERR_NONE;
         rsp_in.last_field  = (idx_ff == xcfu_pkg::IDX_LAST);
         ctl.shift2         = 1'b1;
         idx_in             = idx_ff + 4'd1;
         if (idx_ff == xcfu_pkg::IDX_LAST) begin
            state_in = xcfu_pkg::ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= xcfu_pkg::ST_IDLE;
         pos_ff       <= xcfu_pkg::POS_HEADER;
         xor_ff       <= 8'h00;
         hg_ff        <= 1'b1;
         idx_ff       <= xcfu_pkg::IDX_STATUS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         xor_ff       <= xor_in;
         hg_ff        <= hg_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // no input taken during a drain
   `XCFU_ASSERT_IMP(a_drain_blocks_req, clock, reset,
      state_ff == xcfu_pkg::ST_DRAIN, !req_ready)
   // a good run ends exactly at the last word index
   `XCFU_ASSERT_IMP(a_ok_last_index, clock, reset,
      rsp_valid_ff && rsp_ff.last_field && rsp_ff.frame_error == xcfu_pkg::ERR_NONE,
      rsp_ff.field_index == xcfu_pkg::IDX_LAST)
   // error results are single, empty and final
   `XCFU_ASSERT_IMP(a_err_shape, clock, reset,
      rsp_valid_ff && rsp_ff.frame_error != xcfu_pkg::ERR_NONE,
      rsp_ff.last_field && rsp_ff.field_value == 16'h0000)
   // drain is over once the final word has been loaded
   `XCFU_ASSERT_NXT(a_drain_done, clock, reset,
      state_ff == xcfu_pkg::ST_DRAIN && slot_free && idx_ff == xcfu_pkg::IDX_LAST,
      state_ff == xcfu_pkg::ST_IDLE)

endmodule

/* rtl/xcfu_byte_cell.sv */
// ---------------------------------------------------------------------------
// xcfu_byte_cell
// One byte of the payload chain; loads from the neighbor one or two ahead.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module xcfu_byte_cell (
   input  logic                   clock,
   input  xcfu_pkg::chain_ctl_type ctl,
   input  logic [7:0]             near_byte,
   input  logic [7:0]             far_byte,
   output logic [7:0]             cell_byte
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   always_comb begin
      byte_in = byte_ff;
      if (ctl.shift2) begin
         byte_in = far_byte;
      end else if (ctl.shift1) begin
         byte_in = near_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign cell_byte = byte_ff;

endmodule

/* rtl/xcfu_byte_chain.sv */
// ---------------------------------------------------------------------------
// xcfu_byte_chain
// Row of byte cells: fills at the tail, drains from the head.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module xcfu_byte_chain (
   input  logic                    clock,
   input  xcfu_pkg::chain_ctl_type ctl,
   input  logic [7:0]              tail_byte,
   output logic [7:0]              head_byte0,
   output logic [7:0]              head_byte1
);

   localparam int unsigned Depth = xcfu_pkg::STORE_DEPTH;

   // taps: cells, then the tail byte twice past the end
   logic [7:0] tap [Depth+2];

   genvar gi;
   generate
      for (gi = 0; gi < Depth; gi++) begin : g_cell
         xcfu_byte_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .near_byte (tap[gi+1]),
            .far_byte  (tap[gi+2]),
            .cell_byte (tap[gi])
         );
      end
   endgenerate

   assign tap[Depth]   = tail_byte;
   assign tap[Depth+1] = tail_byte;

   assign head_byte0 = tap[0];
   assign head_byte1 = tap[1];

endmodule
